// ===== sv/divider_64bit_signed_unsigned_macros.svh =====
// Assertion helpers used by the checker file div64_chk.sv
`ifndef DIVIDER_64BIT_SIGNED_UNSIGNED_MACROS_SVH
`define DIVIDER_64BIT_SIGNED_UNSIGNED_MACROS_SVH

// Clocked check, off while reset is asserted
`define DIV_ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("divider check failed");

// Clocked check that also runs during reset
`define DIV_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("divider reset check failed");

`endif

// ===== sv/div64_pkg.sv =====
package div64_pkg;

    // Port width of every data field
    localparam int FIELD_W = 64;

    // Default operand width handed down from the top level
    localparam int DATA_WIDTH_DEF = 64;

    // Mode codes
    localparam logic MODE_UNSIGNED = 1'b0;
    localparam logic MODE_SIGNED   = 1'b1;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_FIX
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;   // capture operands, take magnitudes
        logic step;   // one restoring shift-subtract step
        logic fix;    // sign fix-up into the output register
    } t_dp_cmd;

endpackage

// ===== sv/div64_ctrl.sv =====
module div64_ctrl
    import div64_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd
);

    localparam int CNT_W = $clog2(DATA_WIDTH);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_WIDTH - 1);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    t_dp_cmd          cmd;

    // State, step counter and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and commands
    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        cmd      = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_cnt    = '0;
                    n_state  = ST_CALC;
                end
            end
            ST_CALC: begin
                cmd.step = 1'b1;
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_state = ST_FIX;
                end
            end
            ST_FIX: begin
                // wait until the output register is free or being emptied
                if (!r_out_valid || i_out_ready) begin
                    cmd.fix = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        n_out_valid = (r_out_valid && !i_out_ready) || cmd.fix;
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

endmodule

// ===== sv/div64_dp.sv =====
module div64_dp
    import div64_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic               i_clk,
    input  t_dp_cmd            i_cmd,
    input  logic               i_mode,
    input  logic [FIELD_W-1:0] i_dividend,
    input  logic [FIELD_W-1:0] i_divisor,
    output logic [FIELD_W-1:0] o_quotient,
    output logic [FIELD_W-1:0] o_remainder,
    output logic               o_divide_by_zero
);

    localparam int W = DATA_WIDTH;

    logic [W-1:0] r_rem;     // partial remainder
    logic [W-1:0] r_quo;     // dividend bits shift out, quotient bits shift in
    logic [W-1:0] r_div;     // divisor magnitude
    logic         r_neg_q;
    logic         r_neg_r;
    logic         r_dbz;
    logic [W-1:0] r_out_q;
    logic [W-1:0] r_out_r;
    logic         r_out_dbz;

    logic [W-1:0] a_in, b_in, a_abs, b_abs;
    logic         neg_a, neg_b;
    logic [W:0]   shifted;
    logic [W+1:0] diff;
    logic         fits;
    logic [W-1:0] q_pre, r_pre, q_fix, r_fix;

    // Operand magnitudes at load
    always_comb begin
        a_in  = i_dividend[W-1:0];
        b_in  = i_divisor[W-1:0];
        neg_a = (i_mode == MODE_SIGNED) && a_in[W-1];
        neg_b = (i_mode == MODE_SIGNED) && b_in[W-1];
        a_abs = neg_a ? W'(~a_in + 1'b1) : a_in;
        b_abs = neg_b ? W'(~b_in + 1'b1) : b_in;
    end

    // One restoring step: shift in next dividend bit, subtract if it fits
    always_comb begin
        shifted = {r_rem, r_quo[W-1]};
        diff    = {1'b0, shifted} - {2'b00, r_div};
        fits    = !diff[W+1];
    end

    // Sign fix-up and zero-divisor result
    always_comb begin
        q_pre = r_dbz ? '1 : r_quo;
        r_pre = r_dbz ? '0 : r_rem;
        q_fix = r_neg_q ? W'(~q_pre + 1'b1) : q_pre;
        r_fix = r_neg_r ? W'(~r_pre + 1'b1) : r_pre;
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rem   <= '0;
            r_quo   <= a_abs;
            r_div   <= b_abs;
            r_neg_q <= neg_a ^ neg_b;
            r_neg_r <= neg_a;
            r_dbz   <= (b_in == '0);
        end else if (i_cmd.step) begin
            r_rem <= fits ? diff[W-1:0] : shifted[W-1:0];
            r_quo <= {r_quo[W-2:0], fits};
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.fix) begin
            r_out_q   <= q_fix;
            r_out_r   <= r_fix;
            r_out_dbz <= r_dbz;
        end
    end

    assign o_quotient       = FIELD_W'(r_out_q);
    assign o_remainder      = FIELD_W'(r_out_r);
    assign o_divide_by_zero = r_out_dbz;

endmodule

// ===== sv/divider_64bit_signed_unsigned.sv =====
// Restoring shift-subtract divider, unsigned or signed two's complement.
// Input channel (i_in_valid / o_in_ready) carries mode, dividend and divisor;
// an item transfers when both are high. Output channel (o_out_valid /
// i_out_ready) carries quotient, remainder and the divide-by-zero flag.
// Only the low DATA_WIDTH bits of the operands are used; upper result bits
// are zero. Signed quotients truncate toward zero, remainders take the
// dividend's sign. A zero divisor gives remainder zero and an all-ones
// quotient (negated by the sign rule in signed mode).
// Operands load at the input transfer, then DATA_WIDTH subtract steps run and
// a sign fix-up step writes the output register and sets o_out_valid.
// The single shared subtractor produces one quotient bit per cycle. A new
// item is accepted only back in ST_IDLE, once the last one has been fixed up.
// A finished result sits in the output register; a new item is accepted
// while it waits. If the receiver still stalls when the next result is
// ready, the fix-up cycle holds until the output register frees up.
// Synchronous active-low reset clears the controller and drops o_out_valid.
module divider_64bit_signed_unsigned
    import div64_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_mode,
    input  logic [FIELD_W-1:0] i_dividend,
    input  logic [FIELD_W-1:0] i_divisor,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [FIELD_W-1:0] o_quotient,
    output logic [FIELD_W-1:0] o_remainder,
    output logic               o_divide_by_zero
);

    t_dp_cmd cmd;

    div64_ctrl #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    div64_dp #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_cmd            (cmd),
        .i_mode           (i_mode),
        .i_dividend       (i_dividend),
        .i_divisor        (i_divisor),
        .o_quotient       (o_quotient),
        .o_remainder      (o_remainder),
        .o_divide_by_zero (o_divide_by_zero)
    );

endmodule

// ===== sv/div64_chk.sv =====
`include "divider_64bit_signed_unsigned_macros.svh"

module div64_chk
    import div64_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               i_mode,
    input logic [FIELD_W-1:0] i_dividend,
    input logic [FIELD_W-1:0] i_divisor,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic [FIELD_W-1:0] o_quotient,
    input logic [FIELD_W-1:0] o_remainder,
    input logic               o_divide_by_zero
);

    // A stalled result stays offered
    `DIV_ASSERT_CLK(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid)

    // Reset empties the output register
    `DIV_ASSERT_ALWAYS(a_rst_out, i_clk, !i_rst_n |=> !o_out_valid)

    // One item at a time: input closes right after a transfer
    `DIV_ASSERT_CLK(a_in_busy, i_clk, i_rst_n, i_in_valid && o_in_ready |=> !o_in_ready)

    // Zero divisor always reports a zero remainder
    `DIV_ASSERT_CLK(a_dbz_rem, i_clk, i_rst_n, o_out_valid && o_divide_by_zero |-> o_remainder == '0)

endmodule

bind divider_64bit_signed_unsigned div64_chk u_chk (.*);

// ===== tb/sv/div64_result_checker.sv =====
`timescale 1ns / 100ps

// Watches both channels of the divider, predicts each result and compares it.
module div64_result_checker
    import div64_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic               i_mode,
    input  logic [FIELD_W-1:0] i_dividend,
    input  logic [FIELD_W-1:0] i_divisor,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic [FIELD_W-1:0] i_quotient,
    input  logic [FIELD_W-1:0] i_remainder,
    input  logic               i_divide_by_zero,
    output int                 o_fail_count,
    output int                 o_pending
);

    typedef struct packed {
        logic [FIELD_W-1:0] quotient;
        logic [FIELD_W-1:0] remainder;
        logic               divide_by_zero;
    } t_div_result;

    // Quotients and remainders still owed by the block, oldest first
    t_div_result owed_quotients[$];

    // Divide magnitudes, then apply the sign rules of the selected mode
    function automatic t_div_result divide_expected(input logic mode,
                                                    input logic [FIELD_W-1:0] num,
                                                    input logic [FIELD_W-1:0] den);
        t_div_result res;
        logic neg_num;
        logic neg_den;
        logic [FIELD_W-1:0] mag_num;
        logic [FIELD_W-1:0] mag_den;
        neg_num = (mode == MODE_SIGNED) && num[FIELD_W-1];
        neg_den = (mode == MODE_SIGNED) && den[FIELD_W-1];
        mag_num = neg_num ? -num : num;
        mag_den = neg_den ? -den : den;
        if (mag_den == '0) begin
            // zero divisor: all-ones quotient, zero remainder
            res.quotient       = '1;
            res.remainder      = '0;
            res.divide_by_zero = 1'b1;
        end else begin
            res.quotient       = mag_num / mag_den;
            res.remainder      = mag_num % mag_den;
            res.divide_by_zero = 1'b0;
        end
        // quotient truncates toward zero, remainder follows the dividend
        if (neg_num ^ neg_den) res.quotient = -res.quotient;
        if (neg_num) res.remainder = -res.remainder;
        return res;
    endfunction

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    always @(posedge i_clk) begin
        t_div_result want;
        if (i_rst_n) begin
            // input transfer: queue the prediction
            if (i_in_valid && i_in_ready)
                owed_quotients.push_back(divide_expected(i_mode, i_dividend, i_divisor));
            // output transfer: compare with the oldest prediction
            if (i_out_valid && i_out_ready) begin
                if (owed_quotients.size() == 0) begin
                    $display("%0t: unexpected result q=%h r=%h dbz=%b", $time,
                             i_quotient, i_remainder, i_divide_by_zero);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = owed_quotients.pop_front();
                    if (i_quotient !== want.quotient) begin
                        $display("%0t: quotient expected %h actual %h", $time,
                                 want.quotient, i_quotient);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (i_remainder !== want.remainder) begin
                        $display("%0t: remainder expected %h actual %h", $time,
                                 want.remainder, i_remainder);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (i_divide_by_zero !== want.divide_by_zero) begin
                        $display("%0t: divide_by_zero expected %b actual %b", $time,
                                 want.divide_by_zero, i_divide_by_zero);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
            o_pending = owed_quotients.size();
        end
    end

endmodule

// ===== tb/sv/divider_64bit_signed_unsigned_tb.sv =====
`timescale 1ns / 100ps

module divider_64bit_signed_unsigned_tb;
    import div64_pkg::*;

    localparam logic [FIELD_W-1:0] ALL_ONES = '1;
    localparam logic [FIELD_W-1:0] MOST_NEG = {1'b1, {(FIELD_W-1){1'b0}}};
    localparam logic [FIELD_W-1:0] MOST_POS = {1'b0, {(FIELD_W-1){1'b1}}};
    localparam int RX_HOLD_CYCLES = 400;
    localparam int PHASE_ITEMS    = 250;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic               i_mode = MODE_UNSIGNED;
    logic [FIELD_W-1:0] i_dividend = '0;
    logic [FIELD_W-1:0] i_divisor = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [FIELD_W-1:0] o_quotient;
    logic [FIELD_W-1:0] o_remainder;
    logic               o_divide_by_zero;

    int fail_count;
    int pending;

    // Idle rates per phase, in percent; hold request for the receiver
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    bit rx_hold_req = 1'b0;

    divider_64bit_signed_unsigned dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_mode           (i_mode),
        .i_dividend       (i_dividend),
        .i_divisor        (i_divisor),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_quotient       (o_quotient),
        .o_remainder      (o_remainder),
        .o_divide_by_zero (o_divide_by_zero)
    );

    div64_result_checker checker_i (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_mode           (i_mode),
        .i_dividend       (i_dividend),
        .i_divisor        (i_divisor),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_quotient       (o_quotient),
        .i_remainder      (o_remainder),
        .i_divide_by_zero (o_divide_by_zero),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        #5000000;
        $display("divider_64bit_signed_unsigned_tb: FAIL");
        $finish;
    end

    // Receiver: random stalls, plus one long hold-off on request
    initial begin : rx_drive
        bit hold_done;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_req && !hold_done) begin
                i_out_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end else begin
                i_out_ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // Offer one division; returns at the edge where it transfers
    task automatic offer_division(input logic mode, input logic [FIELD_W-1:0] num,
                                  input logic [FIELD_W-1:0] den);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode     <= mode;
        i_dividend <= num;
        i_divisor  <= den;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // Stop offering and wait for every owed result
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        @(posedge i_clk);
    endtask

    // Operand mix: corner values, full-width random, and short magnitudes
    function automatic logic [FIELD_W-1:0] pick_operand();
        logic [FIELD_W-1:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(11))
            0: v = '0;
            1: v = ALL_ONES;
            2: v = 1;
            3: v = MOST_NEG;
            4: v = MOST_POS;
            5, 6: ;
            default: begin
                v = v >> $urandom_range(FIELD_W - 1);
                if ($urandom_range(1)) v = -v;
            end
        endcase
        return v;
    endfunction

    task automatic run_random(input int count, input int tx_pct, input int rx_pct);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        repeat (count) offer_division(logic'($urandom_range(1)), pick_operand(), pick_operand());
        drain_results();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed corners: zero divisor, zero dividend, wraps, sign combinations
        offer_division(MODE_UNSIGNED, 64'd5, '0);
        offer_division(MODE_UNSIGNED, ALL_ONES, '0);
        offer_division(MODE_SIGNED, -64'd9, '0);
        offer_division(MODE_SIGNED, 64'd9, '0);
        offer_division(MODE_SIGNED, '0, '0);
        offer_division(MODE_UNSIGNED, '0, 64'd3);
        offer_division(MODE_SIGNED, '0, -64'd3);
        offer_division(MODE_SIGNED, MOST_NEG, ALL_ONES);
        offer_division(MODE_SIGNED, MOST_NEG, 64'd1);
        offer_division(MODE_SIGNED, MOST_NEG, MOST_NEG);
        offer_division(MODE_UNSIGNED, ALL_ONES, 64'd1);
        offer_division(MODE_UNSIGNED, ALL_ONES, ALL_ONES);
        offer_division(MODE_UNSIGNED, 64'd1, ALL_ONES);
        offer_division(MODE_UNSIGNED, MOST_NEG, 64'd3);
        offer_division(MODE_SIGNED, -64'd7, 64'd2);
        offer_division(MODE_SIGNED, 64'd7, -64'd2);
        offer_division(MODE_SIGNED, -64'd7, -64'd2);
        offer_division(MODE_UNSIGNED, 64'd100, 64'd7);
        offer_division(MODE_SIGNED, MOST_POS, ALL_ONES);
        offer_division(MODE_UNSIGNED, 64'd3, 64'd10);
        offer_division(MODE_SIGNED, {$urandom, $urandom}, {$urandom, $urandom});
        offer_division(MODE_UNSIGNED, {$urandom, $urandom}, {$urandom, $urandom});
        drain_results();

        // Random traffic under each idling pattern
        run_random(PHASE_ITEMS, 0, 0);
        run_random(PHASE_ITEMS, 69, 0);
        run_random(PHASE_ITEMS, 0, 69);
        run_random(PHASE_ITEMS, 8, 8);

        // Long receiver hold-off while the sender keeps offering
        rx_hold_req = 1'b1;
        run_random(30, 0, 0);
        run_random(100, 30, 30);

        repeat (80) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("divider_64bit_signed_unsigned_tb: PASS");
        end else begin
            $display("divider_64bit_signed_unsigned_tb: FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/div64_pkg.sv
sv/div64_ctrl.sv
sv/div64_dp.sv
sv/divider_64bit_signed_unsigned.sv
sv/div64_chk.sv
tb/sv/div64_result_checker.sv
tb/sv/divider_64bit_signed_unsigned_tb.sv
